// File: rtl/core/sfcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash command sequencer package
// Request codes, flash opcodes and the types shared by the sequencer modules.
// ----------------------------------------------------------------------------
package sfcs_pkg;

    localparam int ADDR_WIDTH_DEFAULT = 24;
    localparam int STEP_WIDTH         = 4;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_PROGRAM = 3'd1,
        OP_BLOCK   = 3'd2,
        OP_CHIP    = 3'd3,
        OP_ID      = 3'd4,
        OP_STATUS  = 3'd5,
        OP_POWER   = 3'd6,
        MODE_RESP  = 3'd7
    } op_t;

    localparam logic [7:0] CMD_WRSR        = 8'h01;
    localparam logic [7:0] CMD_PROGRAM     = 8'h02;
    localparam logic [7:0] CMD_READ        = 8'h03;
    localparam logic [7:0] CMD_RDSR        = 8'h05;
    localparam logic [7:0] CMD_WREN        = 8'h06;
    localparam logic [7:0] CMD_READ_ID     = 8'h90;
    localparam logic [7:0] CMD_RELEASE_PD  = 8'hAB;
    localparam logic [7:0] CMD_CHIP_ERASE  = 8'hC7;
    localparam logic [7:0] CMD_BLOCK_ERASE = 8'hD8;
    localparam logic [7:0] DUMMY_BYTE      = 8'h00;

    localparam logic KIND_TRANSFER = 1'b0;
    localparam logic KIND_REPLY    = 1'b1;

    typedef struct packed {
        logic                  busy;
        op_t                   op;
        logic [STEP_WIDTH-1:0] step;
        logic [7:0]            id_high;
    } ctrl_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  mosi_byte;
        logic        end_of_frame;
        logic [15:0] reply_value;
    } result_t;

endpackage : sfcs_pkg
`default_nettype wire

// File: rtl/core/sfcs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash command sequencer step logic
// Decide the next transfer or host reply for one item and the next control
// state of the sequencer.
// ----------------------------------------------------------------------------
module sfcs_step #(
    parameter int ADDR_WIDTH = sfcs_pkg::ADDR_WIDTH_DEFAULT
) (
    input  wire logic [2:0]            mode,
    input  wire logic [23:0]           flash_address,
    input  wire logic [7:0]            miso_byte,
    input  wire sfcs_pkg::ctrl_t       ctrl,
    input  wire logic [ADDR_WIDTH-1:0] held_address,
    input  wire logic [7:0]            held_data,
    input  wire logic [7:0]            held_block,
    output sfcs_pkg::ctrl_t            ctrl_next,
    output logic                       load_request,
    output logic [ADDR_WIDTH-1:0]      address_masked,
    output sfcs_pkg::result_t          result
);
    import sfcs_pkg::*;

    logic [23:0]           addr_ext;
    op_t                   req_op;
    logic                  poll_busy;
    logic                  at_last;
    logic [STEP_WIDTH-1:0] step_inc;
    logic [8:0]            seq_out;

    function automatic logic [STEP_WIDTH-1:0] last_index(input op_t op);
        logic [STEP_WIDTH-1:0] idx;
        unique case (op)
            OP_READ:    idx = STEP_WIDTH'(6);
            OP_PROGRAM: idx = STEP_WIDTH'(7);
            OP_BLOCK:   idx = STEP_WIDTH'(6);
            OP_CHIP:    idx = STEP_WIDTH'(3);
            OP_ID:      idx = STEP_WIDTH'(5);
            OP_STATUS:  idx = STEP_WIDTH'(1);
            OP_POWER:   idx = STEP_WIDTH'(4);
            default:    idx = '0;
        endcase
        return idx;
    endfunction

    // {end_of_frame, byte} of transfer idx of sequence op
    function automatic logic [8:0] seq_byte(
        input op_t                   op,
        input logic [STEP_WIDTH-1:0] idx,
        input logic [23:0]           addr,
        input logic [7:0]            data,
        input logic [7:0]            blk
    );
        logic [8:0] r;
        r = {1'b1, DUMMY_BYTE};
        if ((op == OP_READ || op == OP_PROGRAM || op == OP_BLOCK || op == OP_CHIP)
            && idx < STEP_WIDTH'(2)) begin
            r = (idx == STEP_WIDTH'(1)) ? {1'b1, DUMMY_BYTE} : {1'b0, CMD_RDSR};
        end else begin
            unique case (op)
                OP_READ:
                begin
                    unique case (idx)
                        STEP_WIDTH'(2): r = {1'b0, CMD_READ};
                        STEP_WIDTH'(3): r = {1'b0, addr[23:16]};
                        STEP_WIDTH'(4): r = {1'b0, addr[15:8]};
                        STEP_WIDTH'(5): r = {1'b0, addr[7:0]};
                        default:        r = {1'b1, DUMMY_BYTE};
                    endcase
                end
                OP_PROGRAM:
                begin
                    unique case (idx)
                        STEP_WIDTH'(2): r = {1'b1, CMD_WREN};
                        STEP_WIDTH'(3): r = {1'b0, CMD_PROGRAM};
                        STEP_WIDTH'(4): r = {1'b0, addr[23:16]};
                        STEP_WIDTH'(5): r = {1'b0, addr[15:8]};
                        STEP_WIDTH'(6): r = {1'b0, addr[7:0]};
                        default:        r = {1'b1, data};
                    endcase
                end
                OP_BLOCK:
                begin
                    unique case (idx)
                        STEP_WIDTH'(2): r = {1'b1, CMD_WREN};
                        STEP_WIDTH'(3): r = {1'b0, CMD_BLOCK_ERASE};
                        STEP_WIDTH'(4): r = {1'b0, blk};
                        STEP_WIDTH'(5): r = {1'b0, DUMMY_BYTE};
                        default:        r = {1'b1, DUMMY_BYTE};
                    endcase
                end
                OP_CHIP:
                begin
                    r = (idx == STEP_WIDTH'(2)) ? {1'b1, CMD_WREN} : {1'b1, CMD_CHIP_ERASE};
                end
                OP_ID:
                begin
                    if (idx == '0) begin
                        r = {1'b0, CMD_READ_ID};
                    end else begin
                        r = {(idx >= STEP_WIDTH'(5)), DUMMY_BYTE};
                    end
                end
                OP_STATUS:
                begin
                    r = (idx == '0) ? {1'b0, CMD_RDSR} : {1'b1, DUMMY_BYTE};
                end
                OP_POWER:
                begin
                    unique case (idx)
                        STEP_WIDTH'(0): r = {1'b1, CMD_RELEASE_PD};
                        STEP_WIDTH'(1): r = {1'b1, CMD_WREN};
                        STEP_WIDTH'(2): r = {1'b0, CMD_WRSR};
                        STEP_WIDTH'(3): r = {1'b0, DUMMY_BYTE};
                        default:        r = {1'b1, DUMMY_BYTE};
                    endcase
                end
                default:
                begin
                    r = {1'b1, DUMMY_BYTE};
                end
            endcase
        end
        return r;
    endfunction

    assign address_masked = flash_address[ADDR_WIDTH-1:0];
    assign addr_ext       = 24'(held_address);
    assign req_op         = op_t'(mode);
    assign poll_busy      = (ctrl.op == OP_READ || ctrl.op == OP_PROGRAM
                             || ctrl.op == OP_BLOCK || ctrl.op == OP_CHIP)
                            && ctrl.step == STEP_WIDTH'(1) && miso_byte[0];
    assign at_last        = ctrl.step >= last_index(ctrl.op);
    assign step_inc       = ctrl.step + STEP_WIDTH'(1);

    always_comb
    begin
        ctrl_next    = ctrl;
        load_request = 1'b0;
        result       = '{valid: 1'b0, kind: KIND_TRANSFER, mosi_byte: DUMMY_BYTE,
                         end_of_frame: 1'b0, reply_value: 16'h0000};
        seq_out      = {1'b1, DUMMY_BYTE};
        if (req_op != MODE_RESP) begin
            if (!ctrl.busy) begin
                load_request   = 1'b1;
                ctrl_next.busy = 1'b1;
                ctrl_next.op   = req_op;
                ctrl_next.step = '0;
                seq_out        = seq_byte(req_op, '0, addr_ext, held_data, held_block);
                result.valid        = 1'b1;
                result.mosi_byte    = seq_out[7:0];
                result.end_of_frame = seq_out[8];
            end
        end else if (ctrl.busy) begin
            result.valid = 1'b1;
            if (poll_busy) begin
                ctrl_next.step      = '0;
                seq_out             = seq_byte(ctrl.op, '0, addr_ext, held_data, held_block);
                result.mosi_byte    = seq_out[7:0];
                result.end_of_frame = seq_out[8];
            end else begin
                if (ctrl.op == OP_ID && ctrl.step == STEP_WIDTH'(4)) begin
                    ctrl_next.id_high = miso_byte;
                end
                if (at_last) begin
                    ctrl_next.busy = 1'b0;
                    result.kind    = KIND_REPLY;
                    unique case (ctrl.op)
                        OP_READ,
                        OP_STATUS: result.reply_value = {8'h00, miso_byte};
                        OP_ID:     result.reply_value = {ctrl.id_high, miso_byte};
                        default:   result.reply_value = 16'h0000;
                    endcase
                end else begin
                    ctrl_next.step      = step_inc;
                    seq_out             = seq_byte(ctrl.op, step_inc, addr_ext,
                                                   held_data, held_block);
                    result.mosi_byte    = seq_out[7:0];
                    result.end_of_frame = seq_out[8];
                end
            end
        end
    end

endmodule : sfcs_step
`default_nettype wire

// File: rtl/core/spi_flash_command_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI flash command sequencer
// Turn host requests and flash response bytes into SPI byte transfers and
// host replies.
// ----------------------------------------------------------------------------
// Pipeline: an item taken into the input register goes through the step logic
// into the result register (input register, step logic, result register).
// Throughput: one item per cycle; the input stalls only while the input
// register holds an item and the result register is full and stalled.
// Reset: asynchronous, active low; the sequencer returns to idle and both
// pipeline registers empty.
module spi_flash_command_sequencer #(
    parameter int ADDR_WIDTH = sfcs_pkg::ADDR_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [23:0] flash_address,
    input  wire logic [7:0]  write_byte,
    input  wire logic [7:0]  block_number,
    input  wire logic [7:0]  miso_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       mosi_byte,
    output logic             end_of_frame,
    output logic [15:0]      reply_value
);
    import sfcs_pkg::*;

    logic                  in_valid_reg;
    logic [2:0]            mode_reg;
    logic [23:0]           address_reg;
    logic [7:0]            write_byte_reg;
    logic [7:0]            block_reg;
    logic [7:0]            miso_reg;

    ctrl_t                 ctrl_reg;
    ctrl_t                 ctrl_next;
    logic [ADDR_WIDTH-1:0] held_address_reg;
    logic [7:0]            held_data_reg;
    logic [7:0]            held_block_reg;

    result_t               out_reg;
    result_t               step_result;
    logic                  load_request;
    logic [ADDR_WIDTH-1:0] address_masked;
    logic                  advance;
    logic                  in_accept;

    assign advance   = !out_reg.valid || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    sfcs_step #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_step (
        .mode           (mode_reg),
        .flash_address  (address_reg),
        .miso_byte      (miso_reg),
        .ctrl           (ctrl_reg),
        .held_address   (held_address_reg),
        .held_data      (held_data_reg),
        .held_block     (held_block_reg),
        .ctrl_next      (ctrl_next),
        .load_request   (load_request),
        .address_masked (address_masked),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            ctrl_reg     <= '{busy: 1'b0, op: OP_READ, step: '0, id_high: 8'h00};
            out_reg      <= '0;
        end else begin
            if (!in_stall) begin
                in_valid_reg <= in_accept;
            end
            if (advance) begin
                if (in_valid_reg) begin
                    ctrl_reg      <= ctrl_next;
                    out_reg.valid <= step_result.valid;
                    if (step_result.valid) begin
                        out_reg.kind         <= step_result.kind;
                        out_reg.mosi_byte    <= step_result.mosi_byte;
                        out_reg.end_of_frame <= step_result.end_of_frame;
                        out_reg.reply_value  <= step_result.reply_value;
                    end
                end else begin
                    out_reg.valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            mode_reg       <= mode;
            address_reg    <= flash_address;
            write_byte_reg <= write_byte;
            block_reg      <= block_number;
            miso_reg       <= miso_byte;
        end
        if (advance && in_valid_reg && load_request) begin
            held_address_reg <= address_masked;
            held_data_reg    <= write_byte_reg;
            held_block_reg   <= block_reg;
        end
    end

    assign out_valid    = out_reg.valid;
    assign kind         = out_reg.kind;
    assign mosi_byte    = out_reg.mosi_byte;
    assign end_of_frame = out_reg.end_of_frame;
    assign reply_value  = out_reg.reply_value;

endmodule : spi_flash_command_sequencer
`default_nettype wire
